### rtl/core/gravity_particle_update_macros.svh
// Assertion macros used by the checker file.
`ifndef GRAVITY_PARTICLE_UPDATE_MACROS_SVH
`define GRAVITY_PARTICLE_UPDATE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define GPUPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The condition must hold at every clock edge outside reset.
`define GPUPD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

### rtl/core/gpupd_pkg.sv
`default_nettype none
package gpupd_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [6:0]  ACTIVE_RST = 7'd0;
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam logic [56:0] WALL_DIVISOR = 57'd6;

  typedef struct packed {
    logic [27:0] pos_x;
    logic [27:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [15:0] mass;
  } entry_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh07FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -34'sh080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [33:0] v);
    return (v > 34'sh07FFFFFFF) || (v < -34'sh080000000);
  endfunction

endpackage
`default_nettype wire

### rtl/core/gravity_particle_update.sv
// A load transaction goes through the write and done states; its result is registered when the output register is free.
// An update visits each other active particle in turn:
// each partner costs a 29-step square root and up to three 32-step divisions on one shared restoring
// divider plus control states, and the tail adds up to two divisions and one per wall bounce.
// One transaction is in work at a time; the next is accepted the cycle after its result is set.
// Synchronous active-low reset clears control and configuration; the table is not cleared.
`default_nettype none
module gravity_particle_update #(
  parameter int MAX_PARTICLES = gpupd_pkg::MAX_PARTICLES_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     in_mode,
  input  wire  [5:0]              in_slot,
  input  wire  [11:0]             in_load_x,
  input  wire  [11:0]             in_load_y,
  input  wire  [15:0]             in_load_mass,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [5:0]              out_slot_out,
  output logic [27:0]             out_x_now,
  output logic [27:0]             out_y_now,
  output logic signed [31:0]      out_speed_x,
  output logic signed [31:0]      out_speed_y,
  output logic                    out_coincident,
  output logic                    out_saturated,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [gpupd_pkg::PADDR_W-1:0] paddr,
  input  wire  [gpupd_pkg::PDATA_W-1:0] pwdata,
  output logic [gpupd_pkg::PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SELF_RD, S_SELF_WT, S_NEXT, S_PART_WT, S_SQUARE, S_D2, S_D2CHK,
    S_SQRT, S_PULL, S_PULL_D, S_MULX, S_COMPX, S_COMPY, S_DIV, S_ACCX, S_ACCX_D,
    S_ACCY_D, S_POS, S_WALLX, S_WALLX_D, S_WALLY, S_WALLY_D, S_WRITE, S_DONE
  } state_t;

  state_t state_r, ret_r;

  logic [6:0]  active_r;
  logic [11:0] width_r, height_r;

  gpupd_pkg::entry_t mem [MAX_PARTICLES];
  gpupd_pkg::entry_t mem_rd_r, wr_data;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr;

  logic [5:0]          slot_r;
  gpupd_pkg::entry_t   me_r;
  logic [CW-1:0]       j_r, n_lim;
  logic                coin_r, sat_r;
  logic signed [28:0]  dx, dy;
  logic [27:0]         adx_r, ady_r;
  logic                sx_r, sy_r;
  logic [55:0]         dxsq_r, dysq_r;
  logic [56:0]         d2_r;
  logic [31:0]         p_r;
  logic [30:0]         f_r;
  logic signed [31:0]  tx_r, ty_r, vx_r, vy_r;
  logic signed [33:0]  px_r, py_r;

  logic [30:0] sq_rem_r;
  logic [28:0] sq_root_r;
  logic [57:0] sq_src_r;
  logic [4:0]  sq_cnt_r;
  logic [32:0] sq_sh, sq_t, sq_sub;

  logic [56:0] dv_rem_r, dv_den_r, dv_rem_in, dv_den_in;
  logic [31:0] dv_low_r, dv_q_r, dv_low_in;
  logic [4:0]  dv_cnt_r;
  logic        dv_start, dv_ge;
  logic [57:0] dv_t, dv_sub;

  logic [58:0] mul_c;
  logic [33:0] m5;
  logic [31:0] tx_mag, ty_mag, vx_mag, vy_mag;
  logic signed [33:0] comp, vsum, top_x, top_y;
  logic signed [31:0] acc_in;
  logic        acc_neg;
  logic        pull_sat, out_x, out_y, cfg_wr;
  logic        j_is_me;

  assign pready   = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign n_lim    = (32'(active_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(active_r);
  assign j_is_me  = (32'(j_r) == 32'(slot_r));

  always_comb begin
    case (paddr[3:2])
      gpupd_pkg::REG_ACTIVE: prdata = 32'(active_r);
      gpupd_pkg::REG_WIDTH:  prdata = 32'(width_r);
      gpupd_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:               prdata = '0;
    endcase
  end

  assign dx = $signed({1'b0, mem_rd_r.pos_x}) - $signed({1'b0, me_r.pos_x});
  assign dy = $signed({1'b0, mem_rd_r.pos_y}) - $signed({1'b0, me_r.pos_y});

  assign sq_sh  = {sq_rem_r, sq_src_r[57:56]};
  assign sq_t   = {2'b00, sq_root_r, 2'b01};
  assign sq_sub = sq_sh - sq_t;

  assign dv_t   = {dv_rem_r, dv_low_r[31]};
  assign dv_ge  = dv_t >= {1'b0, dv_den_r};
  assign dv_sub = dv_t - {1'b0, dv_den_r};

  assign tx_mag = tx_r[31] ? 32'(-tx_r) : tx_r;
  assign ty_mag = ty_r[31] ? 32'(-ty_r) : ty_r;
  assign vx_mag = vx_r[31] ? 32'(-vx_r) : vx_r;
  assign vy_mag = vy_r[31] ? 32'(-vy_r) : vy_r;

  assign pull_sat = {9'b0, p_r, 16'b0} >= d2_r;
  assign top_x = $signed({6'b0, width_r, 16'b0});
  assign top_y = $signed({6'b0, height_r, 16'b0});
  assign out_x = px_r[33] || (px_r > top_x);
  assign out_y = py_r[33] || (py_r > top_y);

  always_comb begin
    acc_in  = '0;
    acc_neg = 1'b0;
    case (state_r)
      S_COMPX: begin
        acc_in  = tx_r;
        acc_neg = sx_r;
      end
      S_COMPY: begin
        acc_in  = ty_r;
        acc_neg = sy_r;
      end
      S_ACCX_D: begin
        acc_in  = vx_r;
        acc_neg = tx_r[31];
      end
      S_ACCY_D: begin
        acc_in  = vy_r;
        acc_neg = ty_r[31];
      end
      default: ;
    endcase
  end

  assign comp = acc_neg ? -$signed(34'(dv_q_r)) : $signed(34'(dv_q_r));
  assign vsum = 34'(acc_in) + comp;

  always_comb begin
    dv_start  = 1'b0;
    dv_rem_in = '0;
    dv_low_in = '0;
    dv_den_in = '0;
    mul_c     = '0;
    m5        = '0;
    case (state_r)
      S_PULL: begin
        if (!pull_sat) begin
          dv_start  = 1'b1;
          dv_rem_in = 57'({p_r, 15'b0});
          dv_den_in = d2_r;
        end
      end
      S_MULX, S_COMPX: begin
        mul_c     = (state_r == S_MULX) ? 59'(f_r) * 59'(adx_r) : 59'(f_r) * 59'(ady_r);
        dv_start  = 1'b1;
        dv_rem_in = 57'(mul_c[58:32]);
        dv_low_in = mul_c[31:0];
        dv_den_in = 57'(sq_root_r);
      end
      S_ACCX: begin
        if (me_r.mass != 16'd0) begin
          dv_start  = 1'b1;
          dv_low_in = tx_mag;
          dv_den_in = 57'(me_r.mass);
        end
      end
      S_ACCX_D: begin
        dv_start  = 1'b1;
        dv_low_in = ty_mag;
        dv_den_in = 57'(me_r.mass);
      end
      S_WALLX, S_WALLY: begin
        m5 = (state_r == S_WALLX) ? {vx_mag, 2'b00} + 34'(vx_mag)
                                  : {vy_mag, 2'b00} + 34'(vy_mag);
        dv_start  = (state_r == S_WALLX) ? out_x : out_y;
        dv_rem_in = 57'(m5[33:32]);
        dv_low_in = m5[31:0];
        dv_den_in = gpupd_pkg::WALL_DIVISOR;
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(slot_r);
    case (state_r)
      S_SELF_RD: rd_en = 1'b1;
      S_NEXT: begin
        rd_en   = (j_r < n_lim) && !j_is_me;
        rd_addr = AW'(j_r);
      end
      default: ;
    endcase
  end

  assign wr_en   = (state_r == S_WRITE);
  assign wr_data = '{pos_x: px_r[27:0], pos_y: py_r[27:0], vel_x: vx_r, vel_y: vy_r,
                     mass: me_r.mass};

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(slot_r)] <= wr_data;
    if (rd_en) mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_rem_r <= dv_rem_in;
      dv_low_r <= dv_low_in;
      dv_den_r <= dv_den_in;
      dv_q_r   <= '0;
      dv_cnt_r <= '0;
    end else if (state_r == S_DIV) begin
      dv_rem_r <= dv_ge ? dv_sub[56:0] : dv_t[56:0];
      dv_low_r <= {dv_low_r[30:0], 1'b0};
      dv_q_r   <= {dv_q_r[30:0], dv_ge};
      dv_cnt_r <= dv_cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_D2CHK) begin
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_src_r  <= {1'b0, d2_r};
      sq_cnt_r  <= '0;
    end else if (state_r == S_SQRT) begin
      if (sq_sh >= sq_t) begin
        sq_rem_r  <= sq_sub[30:0];
        sq_root_r <= {sq_root_r[27:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_sh[30:0];
        sq_root_r <= {sq_root_r[27:0], 1'b0};
      end
      sq_src_r <= {sq_src_r[55:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      out_valid <= 1'b0;
      active_r  <= gpupd_pkg::ACTIVE_RST;
      width_r   <= gpupd_pkg::WIDTH_RST;
      height_r  <= gpupd_pkg::HEIGHT_RST;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          gpupd_pkg::REG_ACTIVE: active_r <= pwdata[6:0];
          gpupd_pkg::REG_WIDTH:  width_r  <= pwdata[11:0];
          gpupd_pkg::REG_HEIGHT: height_r <= pwdata[11:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && (state_r != S_DONE)) out_valid <= 1'b0;
      if (dv_start) state_r <= S_DIV;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            slot_r <= in_slot;
            coin_r <= 1'b0;
            sat_r  <= 1'b0;
            if (32'(in_slot) >= MAX_PARTICLES) begin
              px_r    <= '0;
              py_r    <= '0;
              vx_r    <= '0;
              vy_r    <= '0;
              state_r <= S_DONE;
            end else if (in_mode == gpupd_pkg::MODE_LOAD) begin
              px_r      <= 34'({in_load_x, 16'b0});
              py_r      <= 34'({in_load_y, 16'b0});
              vx_r      <= '0;
              vy_r      <= '0;
              me_r.mass <= in_load_mass;
              state_r   <= S_WRITE;
            end else begin
              state_r <= S_SELF_RD;
            end
          end
        end
        S_SELF_RD: state_r <= S_SELF_WT;
        S_SELF_WT: begin
          me_r    <= mem_rd_r;
          vx_r    <= $signed(mem_rd_r.vel_x);
          vy_r    <= $signed(mem_rd_r.vel_y);
          tx_r    <= '0;
          ty_r    <= '0;
          j_r     <= '0;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (j_r >= n_lim) begin
            state_r <= S_ACCX;
          end else if (j_is_me) begin
            j_r <= j_r + 1'b1;
          end else begin
            state_r <= S_PART_WT;
          end
        end
        S_PART_WT: begin
          adx_r   <= dx[28] ? 28'(-dx) : dx[27:0];
          ady_r   <= dy[28] ? 28'(-dy) : dy[27:0];
          sx_r    <= dx[28];
          sy_r    <= dy[28];
          p_r     <= 32'(me_r.mass) * 32'(mem_rd_r.mass);
          state_r <= S_SQUARE;
        end
        S_SQUARE: begin
          dxsq_r  <= 56'(adx_r) * 56'(adx_r);
          dysq_r  <= 56'(ady_r) * 56'(ady_r);
          state_r <= S_D2;
        end
        S_D2: begin
          d2_r    <= 57'(dxsq_r) + 57'(dysq_r);
          state_r <= S_D2CHK;
        end
        S_D2CHK: begin
          if (d2_r == '0) begin
            coin_r  <= 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= S_NEXT;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: if (sq_cnt_r == 5'd28) state_r <= S_PULL;
        S_PULL: begin
          ret_r <= S_PULL_D;
          if (pull_sat) begin
            f_r     <= 31'h7FFFFFFF;
            sat_r   <= 1'b1;
            state_r <= S_MULX;
          end
        end
        S_PULL_D: begin
          f_r     <= dv_q_r[30:0];
          state_r <= S_MULX;
        end
        S_MULX: ret_r <= S_COMPX;
        S_COMPX: begin
          tx_r  <= gpupd_pkg::sat32(vsum);
          sat_r <= sat_r | gpupd_pkg::ovf32(vsum);
          ret_r <= S_COMPY;
        end
        S_COMPY: begin
          ty_r    <= gpupd_pkg::sat32(vsum);
          sat_r   <= sat_r | gpupd_pkg::ovf32(vsum);
          j_r     <= j_r + 1'b1;
          state_r <= S_NEXT;
        end
        S_DIV: if (dv_cnt_r == 5'd31) state_r <= ret_r;
        S_ACCX: begin
          ret_r <= S_ACCX_D;
          if (me_r.mass == 16'd0) state_r <= S_POS;
        end
        S_ACCX_D: begin
          vx_r  <= gpupd_pkg::sat32(vsum);
          sat_r <= sat_r | gpupd_pkg::ovf32(vsum);
          ret_r <= S_ACCY_D;
        end
        S_ACCY_D: begin
          vy_r    <= gpupd_pkg::sat32(vsum);
          sat_r   <= sat_r | gpupd_pkg::ovf32(vsum);
          state_r <= S_POS;
        end
        S_POS: begin
          px_r    <= $signed({6'b0, me_r.pos_x}) + 34'(vx_r);
          py_r    <= $signed({6'b0, me_r.pos_y}) + 34'(vy_r);
          state_r <= S_WALLX;
        end
        S_WALLX: begin
          ret_r <= S_WALLX_D;
          if (out_x) px_r <= px_r[33] ? '0 : top_x;
          else state_r <= S_WALLY;
        end
        S_WALLX_D: begin
          vx_r    <= vx_r[31] ? dv_q_r : -dv_q_r;
          state_r <= S_WALLY;
        end
        S_WALLY: begin
          ret_r <= S_WALLY_D;
          if (out_y) py_r <= py_r[33] ? '0 : top_y;
          else state_r <= S_WRITE;
        end
        S_WALLY_D: begin
          vy_r    <= vy_r[31] ? dv_q_r : -dv_q_r;
          state_r <= S_WRITE;
        end
        S_WRITE: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            out_slot_out   <= slot_r;
            out_x_now      <= px_r[27:0];
            out_y_now      <= py_r[27:0];
            out_speed_x    <= vx_r;
            out_speed_y    <= vy_r;
            out_coincident <= coin_r;
            out_saturated  <= sat_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/gpupd_checker.sv
`default_nettype none
`include "gravity_particle_update_macros.svh"
module gpupd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [27:0] out_x_now,
  input wire [31:0] out_speed_x,
  input wire        pready
);

  // Only one transaction is in work at a time.
  `GPUPD_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready)
  `GPUPD_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)
  `GPUPD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                     $stable(out_x_now) && $stable(out_speed_x))
  `GPUPD_ASSERT_ALWAYS(a_pready, pready)

endmodule

bind gravity_particle_update gpupd_checker u_gpupd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_x_now(out_x_now),
  .out_speed_x(out_speed_x), .pready(pready)
);
`default_nettype wire

### test/testbench.sv
`default_nettype none
module testbench;

  localparam int N_SLOTS = 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    bit [5:0]  slot;
    bit [27:0] x;
    bit [27:0] y;
    bit [31:0] vx;
    bit [31:0] vy;
    bit        coin;
    bit        sat;
  } particle_state_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_mode;
  logic [5:0] in_slot;
  logic [11:0] in_load_x, in_load_y;
  logic [15:0] in_load_mass;
  logic out_valid, out_ready;
  logic [5:0] out_slot_out;
  logic [27:0] out_x_now, out_y_now;
  logic signed [31:0] out_speed_x, out_speed_y;
  logic out_coincident, out_saturated;
  logic psel, penable, pwrite;
  logic [gpupd_pkg::PADDR_W-1:0] paddr;
  logic [gpupd_pkg::PDATA_W-1:0] pwdata, prdata;
  logic pready;

  gravity_particle_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_slot(in_slot),
    .in_load_x(in_load_x), .in_load_y(in_load_y), .in_load_mass(in_load_mass),
    .out_valid(out_valid), .out_ready(out_ready), .out_slot_out(out_slot_out),
    .out_x_now(out_x_now), .out_y_now(out_y_now),
    .out_speed_x(out_speed_x), .out_speed_y(out_speed_y),
    .out_coincident(out_coincident), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Mirror of the particle table and registers.
  bit [31:0] tbl_px [N_SLOTS];
  bit [31:0] tbl_py [N_SLOTS];
  bit [31:0] tbl_vx [N_SLOTS];
  bit [31:0] tbl_vy [N_SLOTS];
  bit [15:0] tbl_mass [N_SLOTS];
  bit [6:0]  m_active;
  bit [11:0] m_width;
  bit [11:0] m_height;

  particle_state_t pending_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int updates_sent = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic hold_go = 1'b0;

  function automatic longint clamp32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint split_pull(longint unsigned f, longint delta, longint unsigned d);
    longint unsigned mag;
    longint c;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    c = longint'((f * mag) / d);
    return (delta < 0) ? -c : c;
  endfunction

  function automatic void bounce(inout longint pos, inout longint vel, input bit [11:0] lim);
    longint top;
    top = longint'({52'b0, lim}) << 16;
    if (pos > top || pos < 0) begin
      pos = (pos > top) ? top : 0;
      vel = (-vel * 5) / 6;
    end
  endfunction

  function automatic particle_state_t step_particle(bit mode, bit [5:0] s, bit [11:0] lx,
                                                    bit [11:0] ly, bit [15:0] lm);
    particle_state_t r;
    int n;
    longint dx, dy, tx, ty, vx, vy, px, py;
    longint unsigned d2, d, p, f;
    logic [127:0] num;
    bit coin, sat;
    r = '{default: 0};
    r.slot = s;
    if (mode == gpupd_pkg::MODE_LOAD) begin
      tbl_px[s] = {4'b0, lx, 16'b0};
      tbl_py[s] = {4'b0, ly, 16'b0};
      tbl_vx[s] = 0;
      tbl_vy[s] = 0;
      tbl_mass[s] = lm;
      r.x = tbl_px[s][27:0];
      r.y = tbl_py[s][27:0];
      return r;
    end
    coin = 0;
    sat = 0;
    tx = 0;
    ty = 0;
    n = (m_active > N_SLOTS) ? N_SLOTS : m_active;
    for (int j = 0; j < n; j++) begin
      if (j == s) continue;
      dx = longint'(tbl_px[j]) - longint'(tbl_px[s]);
      dy = longint'(tbl_py[j]) - longint'(tbl_py[s]);
      d2 = dx * dx + dy * dy;
      if (d2 == 0) begin
        coin = 1;
        continue;
      end
      d = int_root(d2);
      p = longint'(tbl_mass[s]) * longint'(tbl_mass[j]);
      if ((p << 16) >= d2) begin
        sat = 1;
        f = 64'd2147483647;
      end else begin
        num = {64'b0, p} << 47;
        f = 64'(num / {64'b0, d2});
      end
      tx = clamp32(tx + split_pull(f, dx, d), sat);
      ty = clamp32(ty + split_pull(f, dy, d), sat);
    end
    vx = longint'(signed'(tbl_vx[s]));
    vy = longint'(signed'(tbl_vy[s]));
    if (tbl_mass[s] != 0) begin
      vx = clamp32(vx + tx / longint'(tbl_mass[s]), sat);
      vy = clamp32(vy + ty / longint'(tbl_mass[s]), sat);
    end
    px = longint'(tbl_px[s]) + vx;
    py = longint'(tbl_py[s]) + vy;
    bounce(px, vx, m_width);
    bounce(py, vy, m_height);
    tbl_px[s] = px[31:0];
    tbl_py[s] = py[31:0];
    tbl_vx[s] = vx[31:0];
    tbl_vy[s] = vy[31:0];
    r.x = px[27:0];
    r.y = py[27:0];
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    r.coin = coin;
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // The receiver stalls in patterns and is held off entirely while hold_go is high.
  always @(posedge clk) begin
    particle_state_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result for slot %0d arrived unexpectedly.", out_slot_out);
        end else begin
          e = pending_q.pop_front();
          if (out_slot_out !== e.slot || out_x_now !== e.x || out_y_now !== e.y ||
              out_speed_x !== e.vx || out_speed_y !== e.vy ||
              out_coincident !== e.coin || out_saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected slot %0d x %h y %h vx %h vy %h coin %b sat %b",
                       e.slot, e.x, e.y, e.vx, e.vy, e.coin, e.sat);
              $display("          actual   slot %0d x %h y %h vx %h vy %h coin %b sat %b",
                       out_slot_out, out_x_now, out_y_now, out_speed_x, out_speed_y,
                       out_coincident, out_saturated);
            end
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      out_ready <= !hold_go && (stall_mode == 0 || $urandom_range(0, 3) != 0);
    end
  end

  // Long hold-off of the receiver, counted here once requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        repeat (3000) @(posedge clk);
        hold_go <= 1'b0;
      end
    end
  end

  task automatic send_item(bit mode, bit [5:0] s, bit [11:0] lx, bit [11:0] ly,
                           bit [15:0] lm);
    in_mode <= mode;
    in_slot <= s;
    in_load_x <= lx;
    in_load_y <= ly;
    in_load_mass <= lm;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(step_particle(mode, s, lx, ly, lm));
    items_sent++;
    if (mode == gpupd_pkg::MODE_UPDATE) updates_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_update(bit [5:0] s);
    send_item(gpupd_pkg::MODE_UPDATE, s, 12'($urandom), 12'($urandom), 16'($urandom));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gpupd_pkg::REG_ACTIVE: m_active = value[6:0];
      gpupd_pkg::REG_WIDTH:  m_width = value[11:0];
      gpupd_pkg::REG_HEIGHT: m_height = value[11:0];
      default: ;
    endcase
  endtask

  task automatic test_directed_cases;
    write_reg(gpupd_pkg::REG_ACTIVE, 8);
    write_reg(gpupd_pkg::REG_WIDTH, 4095);
    write_reg(gpupd_pkg::REG_HEIGHT, 4095);
    send_item(gpupd_pkg::MODE_LOAD, 0, 4095, 0, 16'hFFFF);
    send_item(gpupd_pkg::MODE_LOAD, 1, 0, 4095, 1);
    send_item(gpupd_pkg::MODE_LOAD, 2, 100, 100, 16'hFFFF);
    send_item(gpupd_pkg::MODE_LOAD, 3, 101, 100, 16'hFFFF);
    send_item(gpupd_pkg::MODE_LOAD, 4, 300, 200, 500);
    send_item(gpupd_pkg::MODE_LOAD, 5, 300, 200, 700);
    send_item(gpupd_pkg::MODE_LOAD, 6, 4095, 4095, 0);
    send_item(gpupd_pkg::MODE_LOAD, 7, 0, 0, 1);
    for (int s = 0; s < 8; s++) send_update(s);
    send_update(2);
    send_update(4);
    drain();
  endtask

  task automatic test_zero_walls;
    write_reg(gpupd_pkg::REG_WIDTH, 0);
    write_reg(gpupd_pkg::REG_HEIGHT, 0);
    send_update(0);
    send_update(6);
    send_update(3);
    drain();
  endtask

  task automatic test_full_table;
    write_reg(gpupd_pkg::REG_WIDTH, 640);
    write_reg(gpupd_pkg::REG_HEIGHT, 480);
    for (int s = 0; s < N_SLOTS; s++)
      send_item(gpupd_pkg::MODE_LOAD, s, $urandom_range(0, 640), $urandom_range(0, 480),
                $urandom_range(1, 65535));
    drain();
    write_reg(gpupd_pkg::REG_ACTIVE, 127);
    send_update(63);
    send_update(10);
    drain();
    write_reg(gpupd_pkg::REG_ACTIVE, 64);
    send_update(0);
    send_update(40);
    drain();
  endtask

  task automatic test_backpressure;
    write_reg(gpupd_pkg::REG_ACTIVE, 3);
    hold_go <= 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 0)
        send_item(gpupd_pkg::MODE_LOAD, $urandom_range(0, 63), $urandom, $urandom, $urandom);
      else send_update($urandom_range(0, 63));
    end
    drain();
  endtask

  task automatic test_random_traffic;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(gpupd_pkg::REG_ACTIVE, $urandom_range(2, 10));
      write_reg(gpupd_pkg::REG_WIDTH,
                (ph == 0) ? 1 : (ph == 1) ? 4095 : $urandom_range(1, 4095));
      write_reg(gpupd_pkg::REG_HEIGHT,
                (ph == 0) ? 4095 : (ph == 1) ? 1 : $urandom_range(1, 4095));
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 9) < 3)
          send_item(gpupd_pkg::MODE_LOAD, $urandom_range(0, 63), $urandom_range(0, m_width),
                    $urandom_range(0, m_height), $urandom);
        else
          send_update($urandom_range(0, 15));
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = gpupd_pkg::MODE_LOAD;
    in_slot = '0;
    in_load_x = '0;
    in_load_y = '0;
    in_load_mass = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    m_active = gpupd_pkg::ACTIVE_RST;
    m_width = gpupd_pkg::WIDTH_RST;
    m_height = gpupd_pkg::HEIGHT_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed_cases();
    test_zero_walls();
    test_full_table();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (200) @(posedge clk);
    if (pending_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived.", pending_q.size());
    end
    $display("Sent %0d transactions (%0d updates) and checked %0d results in %0d cycles.",
             items_sent, updates_sent, results_seen, cycles);
    $display("Covered wall extremes, zero walls, coincidence, saturation, zero mass and %0s",
             "an oversized active count, with back-pressure.");
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
